>>> rtl/core/assert_macros.svh
// Assertion helpers; clocked on clk_i, disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define M2DE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define M2DE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/core/m2de_pkg.sv
package m2de_pkg;

  localparam int unsigned DeltaW = 11;
  localparam int unsigned AccW   = 16;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 14;

  localparam logic [CfgIdxW-1:0] CfgNoise = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgJump  = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgDecay = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgHold  = 8'd3;

  localparam logic [7:0]  NoiseRst = 8'd2;
  localparam logic [13:0] JumpRst  = 14'd100;
  localparam logic [7:0]  DecayRst = 8'd10;
  localparam logic [1:0]  HoldRst  = 2'd2;

  localparam logic ReqMove = 1'b0;
  localparam logic ReqTick = 1'b1;

  typedef enum logic [2:0] {
    EvNone  = 3'd0,
    EvRight = 3'd1,
    EvLeft  = 3'd2,
    EvDown  = 3'd3,
    EvUp    = 3'd4
  } dir_e;

  typedef logic signed [AccW-1:0] acc_t;

  // Accumulate a delta if its magnitude exceeds the noise floor, saturating.
  function automatic acc_t acc_move(acc_t acc, logic signed [DeltaW-1:0] d,
                                    logic [7:0] noise);
    logic [DeltaW-1:0] mag;
    logic [AccW:0]     sum;
    acc_t              res;
    mag = d[DeltaW-1] ? (~d + 11'd1) : d;
    sum = {acc[AccW-1], acc} + {{(AccW+1-DeltaW){d[DeltaW-1]}}, d};
    res = acc;
    if (mag > {3'b000, noise}) begin
      if (sum[AccW] != sum[AccW-1]) begin
        res = sum[AccW] ? 16'sh8000 : 16'sh7fff;
      end else begin
        res = sum[AccW-1:0];
      end
    end
    return res;
  endfunction

  // Move toward zero by step, stopping at zero.
  function automatic acc_t acc_decay(acc_t acc, logic [7:0] step);
    logic [AccW:0] diff;
    logic [AccW:0] sum;
    acc_t          res;
    diff = {1'b0, acc} - {9'b0, step};
    sum  = {1'b1, acc} + {9'b0, step};
    res  = acc;
    if (!acc[AccW-1] && (acc != '0)) begin
      res = diff[AccW] ? '0 : diff[AccW-1:0];
    end else if (acc[AccW-1]) begin
      res = sum[AccW] ? sum[AccW-1:0] : '0;
    end
    return res;
  endfunction

endpackage

>>> rtl/core/mouse_to_direction_events.sv
// Turns relative mouse moves and timer ticks into joystick direction events,
// one result per item. An accepted item sits in an input register until the
// result register is free, then a single pass of adds, compares and clamps
// updates the axis accumulators and hold countdowns and loads the result
// register; one item is taken every cycle while the output side keeps up.
// Configuration writes are taken at any time (cfg_ready_o is always high) and
// indexes above 3 are dropped.
`include "assert_macros.svh"

module mouse_to_direction_events (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [m2de_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [m2de_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                req_type_i,
  input  logic signed [m2de_pkg::DeltaW-1:0]  delta_x_i,
  input  logic signed [m2de_pkg::DeltaW-1:0]  delta_y_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [2:0]                          direction_event_o
);

  logic [7:0]  noise_q;
  logic [13:0] jump_q;
  logic [7:0]  decay_q;
  logic [1:0]  hold_ticks_q;

  logic                               in_valid_q;
  logic                               req_type_q;
  logic signed [m2de_pkg::DeltaW-1:0] dx_q, dy_q;

  m2de_pkg::acc_t accum_x_q, accum_x_d, accum_y_q, accum_y_d;
  logic [1:0]     hold_x_q, hold_x_d, hold_y_q, hold_y_d;

  logic           out_valid_q;
  m2de_pkg::dir_e dir_q, dir_d;

  logic advance;

  assign cfg_ready_o       = 1'b1;
  assign advance           = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o        = !in_valid_q || advance;
  assign out_valid_o       = out_valid_q;
  assign direction_event_o = dir_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_q      <= m2de_pkg::NoiseRst;
      jump_q       <= m2de_pkg::JumpRst;
      decay_q      <= m2de_pkg::DecayRst;
      hold_ticks_q <= m2de_pkg::HoldRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        m2de_pkg::CfgNoise: noise_q      <= cfg_data_i[7:0];
        m2de_pkg::CfgJump:  jump_q       <= cfg_data_i;
        m2de_pkg::CfgDecay: decay_q      <= cfg_data_i[7:0];
        m2de_pkg::CfgHold:  hold_ticks_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_type_q <= req_type_i;
      dx_q       <= delta_x_i;
      dy_q       <= delta_y_i;
    end
  end

  always_comb begin
    logic signed [m2de_pkg::AccW:0] ax, ay, jt, njt;
    logic [1:0]                     hx, hy;
    accum_x_d = accum_x_q;
    accum_y_d = accum_y_q;
    hold_x_d  = hold_x_q;
    hold_y_d  = hold_y_q;
    dir_d     = m2de_pkg::EvNone;
    hx        = '0;
    hy        = '0;
    jt        = {3'b000, jump_q};
    njt       = -jt;
    if (req_type_q == m2de_pkg::ReqMove) begin
      if (dx_q != '0) hold_x_d = hold_ticks_q;
      if (dy_q != '0) hold_y_d = hold_ticks_q;
      accum_x_d = m2de_pkg::acc_move(accum_x_q, dx_q, noise_q);
      accum_y_d = m2de_pkg::acc_move(accum_y_q, dy_q, noise_q);
      ax = {accum_x_d[m2de_pkg::AccW-1], accum_x_d};
      ay = {accum_y_d[m2de_pkg::AccW-1], accum_y_d};
      if (ax > jt) begin
        accum_x_d = '0;
        dir_d     = m2de_pkg::EvRight;
      end else if (ax < njt) begin
        accum_x_d = '0;
        dir_d     = m2de_pkg::EvLeft;
      end else if (ay > jt) begin
        accum_y_d = '0;
        dir_d     = m2de_pkg::EvDown;
      end else if (ay < njt) begin
        accum_y_d = '0;
        dir_d     = m2de_pkg::EvUp;
      end
    end else begin
      ax = '0;
      ay = '0;
      hx = (hold_x_q != '0) ? hold_x_q - 2'd1 : 2'd0;
      hy = (hold_y_q != '0) ? hold_y_q - 2'd1 : 2'd0;
      hold_x_d = hx;
      hold_y_d = hy;
      if (hx == '0) accum_x_d = m2de_pkg::acc_decay(accum_x_q, decay_q);
      if (hy == '0) accum_y_d = m2de_pkg::acc_decay(accum_y_q, decay_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_x_q <= '0;
      accum_y_q <= '0;
      hold_x_q  <= '0;
      hold_y_q  <= '0;
    end else if (advance) begin
      accum_x_q <= accum_x_d;
      accum_y_q <= accum_y_d;
      hold_x_q  <= hold_x_d;
      hold_y_q  <= hold_y_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      dir_q <= dir_d;
    end
  end

  `M2DE_ASSERT_NEXT(a_tick_no_event, advance && (req_type_q == m2de_pkg::ReqTick),
                    dir_q == m2de_pkg::EvNone)
  `M2DE_ASSERT_NEXT(a_x_fire_clears, advance && ((dir_d == m2de_pkg::EvRight) ||
                    (dir_d == m2de_pkg::EvLeft)), accum_x_q == '0)
  `M2DE_ASSERT_NEXT(a_y_fire_clears, advance && ((dir_d == m2de_pkg::EvDown) ||
                    (dir_d == m2de_pkg::EvUp)), accum_y_q == '0)
  `M2DE_ASSERT_NEXT(a_state_holds, !advance,
                    $stable(accum_x_q) && $stable(accum_y_q) && $stable(hold_x_q))
  `M2DE_ASSERT(a_adv_needs_item, !advance || in_valid_q)

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CycleLimit = 400_000;
  localparam int unsigned LongStall  = 200;
  localparam int unsigned PhaseItems = 250;
  localparam int unsigned SettleCyc  = 4;

  typedef logic signed [m2de_pkg::DeltaW-1:0] delta_t;

  class direction_scoreboard;
    logic [7:0]     noise;
    logic [13:0]    jump;
    logic [7:0]     decay;
    logic [1:0]     hold_load;
    m2de_pkg::acc_t acc_x;
    m2de_pkg::acc_t acc_y;
    logic [1:0]     hold_x;
    logic [1:0]     hold_y;
    m2de_pkg::dir_e expected_dirs[$];
    int             errors;

    function new();
      noise     = m2de_pkg::NoiseRst;
      jump      = m2de_pkg::JumpRst;
      decay     = m2de_pkg::DecayRst;
      hold_load = m2de_pkg::HoldRst;
      acc_x     = '0;
      acc_y     = '0;
      hold_x    = '0;
      hold_y    = '0;
      errors    = 0;
    endfunction

    function void set_reg(logic [m2de_pkg::CfgIdxW-1:0] idx,
                          logic [m2de_pkg::CfgDataW-1:0] data);
      case (idx)
        m2de_pkg::CfgNoise: noise     = data[7:0];
        m2de_pkg::CfgJump:  jump      = data;
        m2de_pkg::CfgDecay: decay     = data[7:0];
        m2de_pkg::CfgHold:  hold_load = data[1:0];
        default: ;
      endcase
    endfunction

    function m2de_pkg::acc_t after_motion(m2de_pkg::acc_t acc, delta_t d);
      int mag;
      int sum;
      mag = (d < 0) ? -int'(d) : int'(d);
      sum = int'(acc);
      if (mag > int'(noise)) begin
        sum = sum + int'(d);
        if (sum > 32767) sum = 32767;
        else if (sum < -32768) sum = -32768;
      end
      return m2de_pkg::acc_t'(sum);
    endfunction

    function m2de_pkg::acc_t after_decay(m2de_pkg::acc_t acc);
      int v;
      v = int'(acc);
      if (v > 0) begin
        v = v - int'(decay);
        if (v < 0) v = 0;
      end else if (v < 0) begin
        v = v + int'(decay);
        if (v > 0) v = 0;
      end
      return m2de_pkg::acc_t'(v);
    endfunction

    function void take_item(logic req, delta_t dx, delta_t dy);
      m2de_pkg::dir_e ev;
      int             jt;
      ev = m2de_pkg::EvNone;
      if (req == m2de_pkg::ReqMove) begin
        if (dx != 0) hold_x = hold_load;
        if (dy != 0) hold_y = hold_load;
        acc_x = after_motion(acc_x, dx);
        acc_y = after_motion(acc_y, dy);
        jt = int'(jump);
        if (int'(acc_x) > jt) begin
          acc_x = '0;
          ev = m2de_pkg::EvRight;
        end else if (int'(acc_x) < -jt) begin
          acc_x = '0;
          ev = m2de_pkg::EvLeft;
        end else if (int'(acc_y) > jt) begin
          acc_y = '0;
          ev = m2de_pkg::EvDown;
        end else if (int'(acc_y) < -jt) begin
          acc_y = '0;
          ev = m2de_pkg::EvUp;
        end
      end else begin
        if (hold_x != 0) hold_x = hold_x - 2'd1;
        if (hold_x == 0) acc_x = after_decay(acc_x);
        if (hold_y != 0) hold_y = hold_y - 2'd1;
        if (hold_y == 0) acc_y = after_decay(acc_y);
      end
      expected_dirs.push_back(ev);
    endfunction

    function void check_event(logic [2:0] got);
      m2de_pkg::dir_e want;
      if (expected_dirs.size() == 0) begin
        $error("direction_event: unexpected transaction, expected none, actual %0d", got);
        errors++;
      end else begin
        want = expected_dirs.pop_front();
        if (got !== want) begin
          $error("direction_event: expected %0d, actual %0d", want, got);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_dirs.size();
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [m2de_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [m2de_pkg::CfgDataW-1:0] cfg_data_i;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic                          req_type_i;
  delta_t                        delta_x_i;
  delta_t                        delta_y_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic [2:0]                    direction_event_o;

  direction_scoreboard sb;
  bit                  long_stall;
  bit                  calm;
  int unsigned         cycle_count;

  mouse_to_direction_events u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .req_type_i        (req_type_i),
    .delta_x_i         (delta_x_i),
    .delta_y_i         (delta_y_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .direction_event_o (direction_event_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Check results before noting inputs taken on the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_event(direction_event_o);
      if (in_valid_i && in_ready_o) sb.take_item(req_type_i, delta_x_i, delta_y_i);
    end
  end

  // Result sink: random stall bursts, one long hold-off on request.
  initial begin
    out_ready_i <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (long_stall) begin
        out_ready_i <= 1'b0;
        repeat (LongStall) @(posedge clk_i);
        long_stall = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat (($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  function automatic delta_t pick_delta(int lo, int hi, bit neg);
    int m;
    m = $urandom_range(hi, lo);
    if (!neg && m > 1023) m = 1023;
    return neg ? delta_t'(-m) : delta_t'(m);
  endfunction

  task automatic send_item(logic req, delta_t dx, delta_t dy, bit quiet);
    if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    delta_x_i  <= dx;
    delta_y_i  <= dy;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic cfg_write(logic [m2de_pkg::CfgIdxW-1:0] idx,
                           logic [m2de_pkg::CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, data);
  endtask

  // Upper data bits are junk on the narrow registers; one stray index per batch.
  task automatic program_regs(logic [7:0] n, logic [13:0] j, logic [7:0] d, logic [1:0] h);
    cfg_write(m2de_pkg::CfgNoise, {6'($urandom), n});
    cfg_write(m2de_pkg::CfgJump, j);
    cfg_write(m2de_pkg::CfgDecay, {6'($urandom), d});
    cfg_write(m2de_pkg::CfgHold, {12'($urandom), h});
    cfg_write(m2de_pkg::CfgIdxW'($urandom_range(4, 255)), m2de_pkg::CfgDataW'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic run_phase(int n_items);
    int     sent;
    int     len;
    int     kind;
    int     lo;
    int     nz;
    bit     neg_x;
    bit     neg_y;
    bit     x_on;
    bit     y_on;
    bit     quiet;
    delta_t dx;
    delta_t dy;
    sent = 0;
    while (sent < n_items) begin
      kind  = $urandom_range(0, 19);
      quiet = ($urandom_range(0, 3) == 0);
      if (kind < 10) begin
        // steady drag, each axis keeps one sign throughout
        len   = $urandom_range(2, 40);
        neg_x = 1'($urandom_range(0, 1));
        neg_y = 1'($urandom_range(0, 1));
        x_on  = ($urandom_range(0, 3) != 0);
        y_on  = ($urandom_range(0, 3) != 0);
        lo    = $urandom_range(0, 1) ? 512 : 1;
        repeat (len) begin
          if ($urandom_range(0, 9) == 0) begin
            send_item(m2de_pkg::ReqTick, delta_t'($urandom), delta_t'($urandom), quiet);
          end else begin
            dx = x_on ? pick_delta(lo, 1024, neg_x) : delta_t'(0);
            dy = y_on ? pick_delta(lo, 1024, neg_y) : delta_t'(0);
            send_item(m2de_pkg::ReqMove, dx, dy, quiet);
          end
        end
        sent += len;
      end else if (kind < 14) begin
        len = $urandom_range(1, 6);
        repeat (len) begin
          send_item(m2de_pkg::ReqTick, delta_t'($urandom), delta_t'($urandom), quiet);
        end
        sent += len;
      end else if (kind < 17) begin
        // jitter around the noise floor
        len = $urandom_range(1, 8);
        nz  = int'(sb.noise);
        lo  = (nz > 0) ? nz - 1 : 0;
        repeat (len) begin
          dx = pick_delta(lo, nz + 1, 1'($urandom_range(0, 1)));
          dy = pick_delta(lo, nz + 1, 1'($urandom_range(0, 1)));
          send_item(m2de_pkg::ReqMove, dx, dy, quiet);
        end
        sent += len;
      end else begin
        len = $urandom_range(1, 8);
        repeat (len) begin
          send_item(1'($urandom_range(0, 1)), delta_t'($urandom), delta_t'($urandom),
                    quiet);
        end
        sent += len;
      end
    end
  endtask

  task automatic directed_items();
    send_item(m2de_pkg::ReqTick, 11'sd1023, -11'sd1024, 1'b0);
    send_item(m2de_pkg::ReqMove, 11'sd2, -11'sd2, 1'b0);
    send_item(m2de_pkg::ReqMove, 11'sd3, -11'sd3, 1'b0);
    send_item(m2de_pkg::ReqMove, 11'sd1023, 11'sd0, 1'b0);
    send_item(m2de_pkg::ReqMove, -11'sd1024, 11'sd0, 1'b0);
    send_item(m2de_pkg::ReqMove, 11'sd0, 11'sd1023, 1'b0);
    send_item(m2de_pkg::ReqMove, 11'sd0, -11'sd1024, 1'b0);
    // both axes over: right wins, y fires on the next move
    send_item(m2de_pkg::ReqMove, 11'sd1023, 11'sd1023, 1'b0);
    send_item(m2de_pkg::ReqMove, 11'sd0, 11'sd0, 1'b0);
    send_item(m2de_pkg::ReqMove, 11'sd60, -11'sd60, 1'b0);
    send_item(m2de_pkg::ReqTick, 11'sd0, 11'sd0, 1'b0);
    send_item(m2de_pkg::ReqTick, 11'sd0, 11'sd0, 1'b0);
    send_item(m2de_pkg::ReqTick, 11'sd0, 11'sd0, 1'b0);
    send_item(m2de_pkg::ReqMove, -11'sd1, 11'sd1, 1'b0);
    send_item(m2de_pkg::ReqTick, 11'sd0, 11'sd0, 1'b0);
    send_item(m2de_pkg::ReqTick, -11'sd1, 11'sd1, 1'b0);
    send_item(m2de_pkg::ReqTick, 11'sd0, 11'sd0, 1'b0);
    send_item(m2de_pkg::ReqMove, 11'sd1, -11'sd1, 1'b0);
  endtask

  initial begin
    sb          = new();
    long_stall  = 1'b0;
    calm        = 1'b0;
    cycle_count = 0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    req_type_i  <= m2de_pkg::ReqMove;
    delta_x_i   <= '0;
    delta_y_i   <= '0;
    rst_ni      <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_items();
    drain();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: program_regs(8'd0, 14'd0, 8'd0, 2'd0);
        1: program_regs(8'd255, 14'd16383, 8'd255, 2'd3);
        2: program_regs(8'd0, 14'd1, 8'd255, 2'd0);
        3: program_regs(m2de_pkg::NoiseRst, m2de_pkg::JumpRst, m2de_pkg::DecayRst,
                        m2de_pkg::HoldRst);
        default: begin
          program_regs($urandom_range(0, 1) ? 8'($urandom_range(0, 8)) : 8'($urandom),
                       ($urandom_range(0, 3) == 0) ? 14'($urandom) :
                                                     14'($urandom_range(0, 1500)),
                       8'($urandom), 2'($urandom));
        end
      endcase
      if (p == 3) long_stall = 1'b1;
      if (p == 7) calm = 1'b1;
      run_phase(PhaseItems);
      drain();
    end

    if (sb.errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/m2de_pkg.sv
rtl/core/mouse_to_direction_events.sv
tb/tb_top.sv
